// ===== sv/tpspwm_pkg.sv =====
// Shared types, constants and the sine compare table generator for the
// three-phase sine PWM block. No dependencies.
package tpspwm_pkg;

   localparam int TABLE_DEPTH = 160;
   localparam int AMPLITUDE   = 1000;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int POS_W       = 8;
   localparam int CMP_W       = 16;
   localparam int CNT_W       = 16;
   localparam int DEAD_W      = 8;
   localparam int PHASES      = 3;
   localparam int GATES       = 2 * PHASES;
   localparam int PADDR_W     = 4;
   localparam int PDATA_W     = 32;

   localparam logic [CNT_W-1:0]  PERIOD_RESET = CNT_W'(1999);
   localparam logic [DEAD_W-1:0] DEAD_RESET   = DEAD_W'(48);

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_PERIOD = 2'd0;
   localparam logic [1:0] REG_DEAD   = 2'd1;
   localparam logic [1:0] REG_RUN    = 2'd2;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [CNT_W-1:0]  period_max;
      logic [DEAD_W-1:0] dead_ticks;
      logic              run_enable;
   } cfg_type;

   typedef struct packed {
      logic [GATES-1:0] gates;    // {c_low, c_high, b_low, b_high, a_low, a_high}
      logic [POS_W-1:0] position;
      logic             wrap;
   } rsp_word_type;

   typedef logic [PHASES-1:0][CMP_W-1:0] cmp_set_type;
   typedef logic [TABLE_DEPTH-1:0][PHASES-1:0][CMP_W-1:0] rom_image_type;

   // Q30 angle constants
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint THIRD_Q30   = ((longint'(628318) <<< 30) + 150000) / 300000;
   localparam u64_type ANG_DEN    = u64_type'(100000) * u64_type'(TABLE_DEPTH - 1);

   // Q30 sine, Taylor series to the 17th power
   function automatic longint fix_sin(input longint x_in);
      longint  x;
      longint  sum;
      u64_type u;
      u64_type x2;
      u64_type term;
      logic    neg;
      x = x_in;
      if (x > PI_Q30) x = x - TWO_PI_Q30;
      if (x > PI_Q30) x = x - TWO_PI_Q30;
      if (x < -PI_Q30) x = x + TWO_PI_Q30;
      if (x < -PI_Q30) x = x + TWO_PI_Q30;
      if (x > HALF_PI_Q30) x = PI_Q30 - x;
      else if (x < -HALF_PI_Q30) x = -PI_Q30 - x;
      neg  = (x < 0);
      u    = neg ? u64_type'(-x) : u64_type'(x);
      x2   = (u * u) >> 30;
      term = u;
      sum  = signed'(u);
      term = ((term * x2) >> 30) / 6;   sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 110; sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 156; sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 210; sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 272; sum = sum + signed'(term);
      return neg ? -sum : sum;
   endfunction

   function automatic logic at_least_pow(input u64_type n, input int e);
      if (e >= 0) return n >= (ANG_DEN << e);
      return (n << (-e)) >= ANG_DEN;
   endfunction

   // Angle rounded to a 24-bit significand, then three phase compares
   function automatic rom_image_type build_rom();
      rom_image_type img;
      u64_type       n;
      u64_type       scaled;
      u64_type       q;
      u64_type       r;
      longint        ang;
      longint        x;
      longint        t;
      int            e;
      img = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         n   = u64_type'(628318) * u64_type'(i);
         ang = 0;
         if (n != 0) begin
            e = 2;
            for (int k = 0; k < 22; k++) begin
               if (e > -20 && !at_least_pow(n, e)) e = e - 1;
            end
            scaled = n << (23 - e);
            q      = scaled / ANG_DEN;
            r      = scaled % ANG_DEN;
            if ((2 * r > ANG_DEN) || ((2 * r == ANG_DEN) && q[0])) q = q + 1;
            if (e + 7 >= 0) ang = signed'(q << (e + 7));
            else ang = signed'(q >> (-(e + 7)));
         end
         for (int p = 0; p < PHASES; p++) begin
            x = (p == 1) ? ang + THIRD_Q30 : ((p == 2) ? ang - THIRD_Q30 : ang);
            t = longint'(AMPLITUDE) * fix_sin(x) + (longint'(AMPLITUDE) <<< 30);
            img[i][p] = (t < 0) ? '0 : CMP_W'(t >>> 30);
         end
      end
      return img;
   endfunction

endpackage

// ===== sv/three_phase_sine_pwm_deadtime.sv =====
// Three-phase sine PWM with complementary gates and rising-edge dead time.
// Each req word is one timer tick (req_tick = 1 advances, 0 holds). Every
// accepted req word gives exactly one rsp word: six gate levels, the sine
// table position whose compares were used, and a flag for a carrier wrap.
// Throughput: one word per cycle while req_stall is low. The compare ROM is
// read in the cycle before use (addressed by the next table position), so the
// counter, compare and dead-time update all complete in the accept cycle.
// The rsp word is registered in the output register when the output is free.
// When rsp_stall is high the output register holds its word and one more
// req word is taken into a skid register; req_stall then rises until the
// output drains.
// Registers over APB: 0x0 period_max, 0x4 dead_ticks, 0x8 run_enable; write
// them only while no word is in flight. pready is always high.
// Reset (synchronous): counter, table position, dead-time counters and
// references clear; period_max = 1999, dead_ticks = 48, run_enable = 0.
// Depends on tpspwm_pkg, tpspwm_csr, tpspwm_rom, tpspwm_core, tpspwm_outbuf.
module three_phase_sine_pwm_deadtime (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_tick,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_gate_a_high,
   output logic                          rsp_gate_a_low,
   output logic                          rsp_gate_b_high,
   output logic                          rsp_gate_b_low,
   output logic                          rsp_gate_c_high,
   output logic                          rsp_gate_c_low,
   output logic [tpspwm_pkg::POS_W-1:0]   rsp_table_position,
   output logic                          rsp_period_wrap,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tpspwm_pkg::PADDR_W-1:0] paddr,
   input  logic [tpspwm_pkg::PDATA_W-1:0] pwdata,
   output logic [tpspwm_pkg::PDATA_W-1:0] prdata,
   output logic                          pready
);
   import tpspwm_pkg::*;

   cfg_type          cfg;
   cmp_set_type      cmp;
   logic [IDX_W-1:0] rom_addr;
   rsp_word_type     core_word;
   rsp_word_type     out_word;
   logic             accept;
   logic             full;

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   tpspwm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tpspwm_rom u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (cmp)
   );

   tpspwm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .tick     (req_tick),
      .cmp      (cmp),
      .rom_addr (rom_addr),
      .result   (core_word)
   );

   tpspwm_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (core_word),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_word)
   );

   assign rsp_gate_a_high    = out_word.gates[0];
   assign rsp_gate_a_low     = out_word.gates[1];
   assign rsp_gate_b_high    = out_word.gates[2];
   assign rsp_gate_b_low     = out_word.gates[3];
   assign rsp_gate_c_high    = out_word.gates[4];
   assign rsp_gate_c_low     = out_word.gates[5];
   assign rsp_table_position = out_word.position;
   assign rsp_period_wrap    = out_word.wrap;

endmodule

// ===== sv/tpspwm_csr.sv =====
// APB-style configuration registers: period_max, dead_ticks, run_enable.
// Depends on tpspwm_pkg.
module tpspwm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tpspwm_pkg::PADDR_W-1:0] paddr,
   input  logic [tpspwm_pkg::PDATA_W-1:0] pwdata,
   output logic [tpspwm_pkg::PDATA_W-1:0] prdata,
   output logic                          pready,
   output tpspwm_pkg::cfg_type           cfg
);
   import tpspwm_pkg::*;

   logic [CNT_W-1:0]  period_ff, period_in;
   logic [DEAD_W-1:0] dead_ff, dead_in;
   logic              run_ff, run_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      period_in = period_ff;
      dead_in   = dead_ff;
      run_in    = run_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PERIOD: period_in = pwdata[CNT_W-1:0];
            REG_DEAD:   dead_in   = pwdata[DEAD_W-1:0];
            REG_RUN:    run_in    = pwdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PERIOD: prdata = PDATA_W'(period_ff);
         REG_DEAD:   prdata = PDATA_W'(dead_ff);
         REG_RUN:    prdata = PDATA_W'(run_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         dead_ff   <= DEAD_RESET;
         run_ff    <= 1'b0;
      end else begin
         period_ff <= period_in;
         dead_ff   <= dead_in;
         run_ff    <= run_in;
      end
   end

   assign cfg.period_max = period_ff;
   assign cfg.dead_ticks = dead_ff;
   assign cfg.run_enable = run_ff;

endmodule

// ===== sv/tpspwm_rom.sv =====
// Synchronous sine compare ROM with a registered read, three phases per word.
// Depends on tpspwm_pkg (table generator).
module tpspwm_rom (
   input  logic                        clock,
   input  logic [tpspwm_pkg::IDX_W-1:0] rd_addr,
   output tpspwm_pkg::cmp_set_type     rd_data
);
   import tpspwm_pkg::*;

   localparam rom_image_type ROM_IMAGE = build_rom();

   cmp_set_type rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= ROM_IMAGE[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tpspwm_core.sv =====
// Carrier counter, table position, phase references and dead-time counters.
// Depends on tpspwm_pkg; compares come from tpspwm_rom in the cycle after address.
module tpspwm_core (
   input  logic                        clock,
   input  logic                        reset,
   input  tpspwm_pkg::cfg_type         cfg,
   input  logic                        accept,
   input  logic                        tick,
   input  tpspwm_pkg::cmp_set_type     cmp,
   output logic [tpspwm_pkg::IDX_W-1:0] rom_addr,
   output tpspwm_pkg::rsp_word_type    result
);
   import tpspwm_pkg::*;

   logic [CNT_W-1:0]  carrier_ff, carrier_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [PHASES-1:0] ref_ff, ref_in;
   logic              active_ff, active_in;
   logic [DEAD_W-1:0] dead_ff [GATES];
   logic [DEAD_W-1:0] dead_in [GATES];
   logic              wrap;
   logic [PHASES-1:0] level;
   logic              want;
   logic              prev;

   always_comb begin
      carrier_in = carrier_ff;
      index_in   = index_ff;
      ref_in     = ref_ff;
      active_in  = active_ff;
      dead_in    = dead_ff;
      wrap       = 1'b0;
      want       = 1'b0;
      prev       = 1'b0;
      for (int p = 0; p < PHASES; p++) level[p] = carrier_ff < cmp[p];
      if (accept) begin
         if (!cfg.run_enable) begin
            for (int g = 0; g < GATES; g++) dead_in[g] = '0;
            ref_in    = '0;
            active_in = 1'b0;
         end else if (tick) begin
            for (int p = 0; p < PHASES; p++) begin
               for (int k = 0; k < 2; k++) begin
                  want = (k == 0) ? level[p] : ~level[p];
                  prev = active_ff & ((k == 0) ? ref_ff[p] : ~ref_ff[p]);
                  if (!want) dead_in[2*p+k] = '0;
                  else if (!prev) dead_in[2*p+k] = cfg.dead_ticks;
                  else if (dead_ff[2*p+k] != '0) dead_in[2*p+k] = dead_ff[2*p+k] - 1'b1;
               end
            end
            ref_in    = level;
            active_in = 1'b1;
            if (carrier_ff >= cfg.period_max) begin
               carrier_in = '0;
               wrap       = 1'b1;
               index_in   = (index_ff >= IDX_W'(TABLE_DEPTH - 1)) ? '0 : index_ff + 1'b1;
            end else begin
               carrier_in = carrier_ff + 1'b1;
            end
         end
      end
   end

   // prefetch: ROM always holds the entry for the index in use next cycle
   assign rom_addr = reset ? '0 : index_in;

   always_comb begin
      for (int p = 0; p < PHASES; p++) begin
         result.gates[2*p]   = active_in & ref_in[p] & (dead_in[2*p] == '0);
         result.gates[2*p+1] = active_in & ~ref_in[p] & (dead_in[2*p+1] == '0);
      end
      result.position = POS_W'(index_ff);
      result.wrap     = wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_ff <= '0;
         index_ff   <= '0;
         ref_ff     <= '0;
         active_ff  <= 1'b0;
         for (int g = 0; g < GATES; g++) dead_ff[g] <= '0;
      end else begin
         carrier_ff <= carrier_in;
         index_ff   <= index_in;
         ref_ff     <= ref_in;
         active_ff  <= active_in;
         dead_ff    <= dead_in;
      end
   end

endmodule

// ===== sv/tpspwm_outbuf.sv =====
// Result output register with one skid word; stalls the input when the skid is full.
// Depends on tpspwm_pkg.
module tpspwm_outbuf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  tpspwm_pkg::rsp_word_type in_data,
   output logic                     full,
   output logic                     out_valid,
   input  logic                     out_stall,
   output tpspwm_pkg::rsp_word_type out_data
);
   import tpspwm_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_data_ff, out_data_in;
   rsp_word_type skid_data_ff, skid_data_in;
   logic         out_free;

   assign out_free = ~out_valid_ff | ~out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff & out_stall;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== dv/testbench.sv =====
// Testbench for three_phase_sine_pwm_deadtime: tick words in, gate words out.
// Uses tpspwm_pkg for widths and register indexes; carries its own compare
// table generator and timer/dead-time predictor, checked word by word.
module testbench;
   import tpspwm_pkg::*;

   localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped index, writes ignored
   localparam longint PI_Q      = 64'sd3373259426;
   localparam longint HALF_PI_Q = 64'sd1686629713;
   localparam longint TWO_PI_Q  = 64'sd6746518852;

   typedef struct packed {
      logic       a_high;
      logic       a_low;
      logic       b_high;
      logic       b_low;
      logic       c_high;
      logic       c_low;
      logic [7:0] position;
      logic       wrap;
   } gate_word_type;

   logic clock;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_tick  = 1'b0;
   logic                 rsp_stall = 1'b0;
   logic                 psel      = 1'b0;
   logic                 penable   = 1'b0;
   logic                 pwrite    = 1'b0;
   logic [PADDR_W-1:0]   paddr     = '0;
   logic [PDATA_W-1:0]   pwdata    = '0;
   wire                  req_stall;
   wire                  rsp_valid;
   wire                  rsp_gate_a_high, rsp_gate_a_low;
   wire                  rsp_gate_b_high, rsp_gate_b_low;
   wire                  rsp_gate_c_high, rsp_gate_c_low;
   wire [POS_W-1:0]      rsp_table_position;
   wire                  rsp_period_wrap;
   wire [PDATA_W-1:0]    prdata;
   wire                  pready;

   three_phase_sine_pwm_deadtime dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_tick(req_tick),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_gate_a_high(rsp_gate_a_high), .rsp_gate_a_low(rsp_gate_a_low),
      .rsp_gate_b_high(rsp_gate_b_high), .rsp_gate_b_low(rsp_gate_b_low),
      .rsp_gate_c_high(rsp_gate_c_high), .rsp_gate_c_low(rsp_gate_c_low),
      .rsp_table_position(rsp_table_position), .rsp_period_wrap(rsp_period_wrap),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   logic [15:0] cmp_rom [TABLE_DEPTH][PHASES];
   logic [15:0] pwm_count;
   logic [7:0]  table_pos;
   logic [7:0]  dead_left [GATES];
   logic [2:0]  ref_level;
   logic        running;
   logic [15:0] cfg_period;
   logic [7:0]  cfg_dead;
   logic        cfg_run;

   logic          tick_queue [$];
   gate_word_type gate_expect [$];
   gate_word_type front_word;
   int            sender_idle_pct   = 0;
   int            receiver_idle_pct = 0;
   int            mismatches        = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

   // Q30 sine: fold into [-pi/2, pi/2], odd Taylor terms through x^17
   function automatic longint q30_sine(input longint x_in);
      longint          x;
      longint          acc;
      longint unsigned u;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned div_k;
      logic            neg;
      x = x_in;
      while (x > PI_Q) x = x - TWO_PI_Q;
      while (x < -PI_Q) x = x + TWO_PI_Q;
      if (x > HALF_PI_Q) x = PI_Q - x;
      else if (x < -HALF_PI_Q) x = -PI_Q - x;
      neg  = (x < 0);
      u    = neg ? u64_type'(-x) : u64_type'(x);
      x2   = (u * u) >> 30;
      term = u;
      acc  = $signed(u);
      for (int k = 1; k <= 8; k++) begin
         div_k = 64'((2 * k) * (2 * k + 1));
         term  = ((term * x2) >> 30) / div_k;
         if (k % 2 == 1) acc = acc - $signed(term);
         else acc = acc + $signed(term);
      end
      return neg ? -acc : acc;
   endfunction

   // angle rounded to a 24-bit significand, then three offset compares
   task automatic build_compare_rom();
      longint unsigned den;
      longint unsigned n;
      longint unsigned scaled;
      longint unsigned q;
      longint unsigned r;
      longint          third;
      longint          ang;
      longint          x;
      longint          t;
      int              e;
      den   = 64'd100000 * (TABLE_DEPTH - 1);
      third = $signed(((64'd628318 << 30) + 64'd150000) / 64'd300000);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         n   = 64'd628318 * i;
         ang = 0;
         if (n != 0) begin
            e = 2;
            while (e > -20 && !((e >= 0) ? (n >= (den << e)) : ((n << (-e)) >= den)))
               e = e - 1;
            scaled = n << (23 - e);
            q      = scaled / den;
            r      = scaled % den;
            if ((2 * r > den) || ((2 * r == den) && q[0])) q = q + 1;
            if (e + 7 >= 0) ang = $signed(q << (e + 7));
            else ang = $signed(q >> (-(e + 7)));
         end
         for (int p = 0; p < PHASES; p++) begin
            x = ang + ((p == 1) ? third : ((p == 2) ? -third : 64'sd0));
            t = 64'sd1000 * q30_sine(x) + (64'sd1000 <<< 30);
            cmp_rom[i][p] = (t < 0) ? 16'd0 : t[45:30];
         end
      end
   endtask

   // one timer clock: carrier, table position, references, dead time
   function automatic gate_word_type advance_timer(input logic tick);
      gate_word_type w;
      logic [7:0]    pos;
      logic [7:0]    idx;
      logic          wrap;
      logic          lvl;
      logic [1:0]    want;
      logic [1:0]    prev;
      logic [5:0]    drive;
      int            g;
      pos  = table_pos;
      wrap = 1'b0;
      if (!cfg_run) begin
         for (int k = 0; k < GATES; k++) dead_left[k] = '0;
         ref_level = '0;
         running   = 1'b0;
      end else if (tick) begin
         idx = (table_pos < TABLE_DEPTH) ? table_pos : 8'd0;
         for (int p = 0; p < PHASES; p++) begin
            lvl  = pwm_count < cmp_rom[idx][p];
            want = {!lvl, lvl};
            // first running tick counts as a rising edge on both gates
            prev = {running && !ref_level[p], running && ref_level[p]};
            for (int k = 0; k < 2; k++) begin
               g = 2 * p + k;
               if (!want[k]) dead_left[g] = '0;
               else if (!prev[k]) dead_left[g] = cfg_dead;
               else if (dead_left[g] != 0) dead_left[g] = dead_left[g] - 8'd1;
            end
            ref_level[p] = lvl;
         end
         running = 1'b1;
         pos     = idx;
         if (pwm_count >= cfg_period) begin
            pwm_count = '0;
            wrap      = 1'b1;
            table_pos = (idx >= TABLE_DEPTH - 1) ? 8'd0 : idx + 8'd1;
         end else begin
            pwm_count = pwm_count + 16'd1;
         end
      end
      for (int p = 0; p < PHASES; p++) begin
         drive[2*p]   = running && ref_level[p] && (dead_left[2*p] == 0);
         drive[2*p+1] = running && !ref_level[p] && (dead_left[2*p+1] == 0);
      end
      w.a_high   = drive[0];
      w.a_low    = drive[1];
      w.b_high   = drive[2];
      w.b_low    = drive[3];
      w.c_high   = drive[4];
      w.c_low    = drive[5];
      w.position = pos;
      w.wrap     = wrap;
      return w;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // driver: one word held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) gate_expect.push_back(advance_timer(req_tick));
         if (!req_valid || !req_stall) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_tick  <= tick_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (gate_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("rsp word with nothing expected");
            end else begin
               front_word = gate_expect.pop_front();
               check_field("gate_a_high", front_word.a_high, rsp_gate_a_high);
               check_field("gate_a_low", front_word.a_low, rsp_gate_a_low);
               check_field("gate_b_high", front_word.b_high, rsp_gate_b_high);
               check_field("gate_b_low", front_word.b_low, rsp_gate_b_low);
               check_field("gate_c_high", front_word.c_high, rsp_gate_c_high);
               check_field("gate_c_low", front_word.c_low, rsp_gate_c_low);
               check_field("table_position", front_word.position, rsp_table_position);
               check_field("period_wrap", front_word.wrap, rsp_period_wrap);
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   task automatic drain();
      while (tick_queue.size() != 0 || req_valid || gate_expect.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_index, input logic [31:0] value);
      drain();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (reg_index)
         REG_PERIOD: cfg_period = value[15:0];
         REG_DEAD:   cfg_dead   = value[7:0];
         REG_RUN:    cfg_run    = value[0];
         default:    ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_ticks(input logic [15:0] pattern, input int count);
      for (int i = 0; i < count; i++) tick_queue.push_back(pattern[i]);
   endtask

   initial begin
      logic [15:0] per;
      logic [7:0]  dly;
      logic        run;
      int          count;
      build_compare_rom();
      pwm_count  = '0;
      table_pos  = '0;
      for (int k = 0; k < GATES; k++) dead_left[k] = '0;
      ref_level  = '0;
      running    = 1'b0;
      cfg_period = 16'd1999;
      cfg_dead   = 8'd48;
      cfg_run    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_idle_pct   = 28;
      receiver_idle_pct = 51;
      // disabled out of reset: everything held, gates low
      push_ticks(16'b101, 3);
      // zero period wraps every tick; no dead time
      csr_write(REG_RUN, 32'hFFFF_FFFF);
      csr_write(REG_DEAD, 32'h0000_0000);
      csr_write(REG_PERIOD, 32'h0000_0000);
      push_ticks(16'b110111, 6);
      // widest period and dead time: pulses swallowed by dead time
      csr_write(REG_PERIOD, 32'h0000_FFFF);
      csr_write(REG_DEAD, 32'h0000_00FF);
      push_ticks(16'b0111111, 7);
      // period lowered under the running count
      csr_write(REG_PERIOD, 32'hABCD_0002);
      push_ticks(16'b1111, 4);
      // unmapped index, then disable and restart with short dead time
      csr_write(REG_SPARE, $urandom());
      csr_write(REG_RUN, 32'h0000_0000);
      push_ticks(16'b01, 2);
      csr_write(REG_DEAD, 32'h1200_0001);
      csr_write(REG_RUN, 32'h0000_0001);
      push_ticks(16'b111, 3);

      for (int ph = 0; ph < 12; ph++) begin
         if (ph < 4) begin
            sender_idle_pct   = 28;
            receiver_idle_pct = 51;
         end else if (ph < 8) begin
            sender_idle_pct   = 51;
            receiver_idle_pct = 28;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         case ($urandom_range(9))
            0:       per = 16'd0;
            1:       per = 16'd1;
            2, 3, 4: per = 16'($urandom_range(2, 6));
            5, 6:    per = 16'($urandom_range(7, 40));
            7:       per = 16'($urandom_range(41, 300));
            8:       per = 16'($urandom());
            default: per = 16'hFFFF;
         endcase
         // fast wraps in each mode so the table position moves on through the table
         if (ph % 4 == 0) per = 16'($urandom_range(0, 1));
         case ($urandom_range(4))
            0:       dly = 8'd0;
            1:       dly = 8'd255;
            2:       dly = 8'($urandom_range(1, 4));
            3:       dly = 8'($urandom_range(5, 60));
            default: dly = 8'($urandom());
         endcase
         run = ($urandom_range(9) != 0);
         csr_write(REG_PERIOD, ($urandom() & 32'hFFFF_0000) | per);
         csr_write(REG_DEAD, ($urandom() & 32'hFFFF_FF00) | dly);
         csr_write(REG_RUN, ($urandom() & 32'hFFFF_FFFE) | run);
         count = $urandom_range(120, 160);
         for (int i = 0; i < count; i++) tick_queue.push_back($urandom_range(99) < 85);
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && gate_expect.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/tpspwm_pkg.sv
sv/tpspwm_csr.sv
sv/tpspwm_rom.sv
sv/tpspwm_core.sv
sv/tpspwm_outbuf.sv
sv/three_phase_sine_pwm_deadtime.sv
dv/testbench.sv
